>>> rtl/button_press_classifier_macros.svh
// assertion macros for the button press classifier
`ifndef BUTTON_PRESS_CLASSIFIER_MACROS_SVH
`define BUTTON_PRESS_CLASSIFIER_MACROS_SVH
`ifndef SYNTHESIS
`define BPC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bpc assertion failed");
`define BPC_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("bpc forbidden condition seen");
`else
`define BPC_ASSERT(lbl, clk, rst_n, prop)
`define BPC_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

>>> rtl/bpc_pkg.sv
// shared widths, codes and reset values of the button press classifier
`default_nettype none
package bpc_pkg;

  localparam int unsigned StepW  = 8;
  localparam int unsigned ThrW   = 14;
  localparam int unsigned CntW   = 16;
  localparam int unsigned KindW  = 3;
  localparam int unsigned EdgeW  = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 14;

  typedef logic [KindW-1:0]    kind_t;
  typedef logic [EdgeW-1:0]    edge_t;
  typedef logic [CfgIdxW-1:0]  cfg_idx_t;
  typedef logic [CfgDataW-1:0] cfg_data_t;
  typedef logic [StepW-1:0]    step_t;
  typedef logic [ThrW-1:0]     thr_t;
  typedef logic [CntW-1:0]     cnt_t;

  localparam kind_t KIND_NONE    = 3'd0;
  localparam kind_t KIND_SHORT   = 3'd1;
  localparam kind_t KIND_LONG    = 3'd2;
  localparam kind_t KIND_DOUBLE  = 3'd3;
  localparam kind_t KIND_UNKNOWN = 3'd4;

  localparam edge_t EDGE_RISE = 2'd1;
  localparam edge_t EDGE_FALL = 2'd2;

  localparam cfg_idx_t REG_TICK_STEP    = 3'd0;
  localparam cfg_idx_t REG_SHORT_MIN    = 3'd1;
  localparam cfg_idx_t REG_SHORT_MAX    = 3'd2;
  localparam cfg_idx_t REG_LONG_MIN     = 3'd3;
  localparam cfg_idx_t REG_LONG_MAX     = 3'd4;
  localparam cfg_idx_t REG_WINDOW_LIMIT = 3'd5;

  localparam step_t RST_TICK_STEP    = 8'd10;
  localparam thr_t  RST_SHORT_MIN    = 14'd50;
  localparam thr_t  RST_SHORT_MAX    = 14'd400;
  localparam thr_t  RST_LONG_MIN     = 14'd800;
  localparam thr_t  RST_LONG_MAX     = 14'd3000;
  localparam thr_t  RST_WINDOW_LIMIT = 14'd4000;

endpackage
`default_nettype wire

>>> rtl/bpc_if.sv
// handshake interfaces for tick, result and configuration words
`default_nettype none
interface bpc_tick_if;
  import bpc_pkg::*;
  logic  valid;
  logic  ready;
  logic  button_level;
  edge_t button_edge;
  modport source (output valid, output button_level, output button_edge, input ready);
  modport sink (input valid, input button_level, input button_edge, output ready);
endinterface

interface bpc_press_if;
  import bpc_pkg::*;
  logic  valid;
  logic  ready;
  kind_t press_kind;
  modport source (output valid, output press_kind, input ready);
  modport sink (input valid, input press_kind, output ready);
endinterface

interface bpc_cfg_if;
  import bpc_pkg::*;
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/button_press_classifier.sv
// button press classifier: short, long, double and unknown press detection
//
//   channel  dir  payload                      handshake
//   tick_i   in   button_level, button_edge    valid/ready
//   press_o  out  press_kind                   valid/ready
//   cfg_i    in   index, data                  valid/ready, always ready
//
// one tick word per cycle while tick_i.ready is high; its result is offered once it moves into the result register
// input register and result register give a two-word pipeline, state updates in one pass
// rst_ni clears counters, pending flag, valid bits and restores register defaults
// a stalled result holds the pipeline; tick_i.ready drops only when both stages are full
// and the result is not taken
`default_nettype none
`include "button_press_classifier_macros.svh"
module button_press_classifier (
  input  wire          clk_i,
  input  wire          rst_ni,
  bpc_tick_if.sink     tick_i,
  bpc_press_if.source  press_o,
  bpc_cfg_if.sink      cfg_i
);
  import bpc_pkg::*;

  step_t tick_step_q;
  thr_t  short_min_q, short_max_q, long_min_q, long_max_q, window_limit_q;

  cnt_t  window_q, window_d;
  cnt_t  held_q, held_d;
  logic  pending_q, pending_d;

  logic  in_valid_q;
  logic  level_q;
  edge_t edge_q;
  logic  out_valid_q;
  kind_t kind_q, kind_d;

  logic  advance;
  logic  proc_en;
  logic  cleared;
  cnt_t  win_inc, held_inc;
  logic [CntW:0] win_sum, held_sum;

  assign advance = !out_valid_q || press_o.ready;
  assign proc_en = advance && in_valid_q;

  assign tick_i.ready     = !in_valid_q || advance;
  assign press_o.valid    = out_valid_q;
  assign press_o.press_kind = kind_q;
  assign cfg_i.ready      = 1'b1;

  function automatic kind_t classify(input cnt_t held, input thr_t smin, input thr_t smax,
                                     input thr_t lmin, input thr_t lmax);
    kind_t k;
    if (held < {2'b00, smin}) begin
      k = KIND_UNKNOWN;
    end else if (held < {2'b00, smax}) begin
      k = KIND_SHORT;
    end else if (held < {2'b00, lmin}) begin
      k = KIND_UNKNOWN;
    end else if (held < {2'b00, lmax}) begin
      k = KIND_LONG;
    end else begin
      k = KIND_UNKNOWN;
    end
    return k;
  endfunction

  // saturating counter increments
  assign win_sum  = {1'b0, window_q} + {{(CntW+1-StepW){1'b0}}, tick_step_q};
  assign held_sum = {1'b0, held_q} + {{(CntW+1-StepW){1'b0}}, tick_step_q};
  assign win_inc  = win_sum[CntW] ? {CntW{1'b1}} : win_sum[CntW-1:0];
  assign held_inc = held_sum[CntW] ? {CntW{1'b1}} : held_sum[CntW-1:0];

  always_comb begin
    window_d  = window_q;
    held_d    = held_q;
    pending_d = pending_q;
    kind_d    = KIND_NONE;
    cleared   = 1'b0;
    if (window_q != '0) begin
      window_d = win_inc;
      if (level_q) begin
        held_d = held_inc;
      end
      if (window_d > {2'b00, window_limit_q}) begin
        kind_d  = (held_d == window_d) ? KIND_LONG : KIND_NONE;
        cleared = 1'b1;
      end else if (edge_q == EDGE_FALL) begin
        kind_d = classify(held_d, short_min_q, short_max_q, long_min_q, long_max_q);
        held_d = '0;
        if (kind_d == KIND_UNKNOWN) begin
          window_d = '0;
        end
      end
      if (kind_d == KIND_SHORT) begin
        if (pending_d) begin
          kind_d  = KIND_DOUBLE;
          cleared = 1'b1;
        end else begin
          kind_d    = KIND_NONE;
          pending_d = 1'b1;
        end
      end
      if (!cleared && pending_d && window_d > {2'b00, short_max_q}) begin
        kind_d  = KIND_SHORT;
        cleared = 1'b1;
      end
      if (cleared) begin
        window_d  = '0;
        held_d    = '0;
        pending_d = 1'b0;
      end
    end
    // held time is zero whenever the window is closed
    if (!cleared && edge_q == EDGE_RISE && window_d == '0) begin
      window_d = {{(CntW-StepW){1'b0}}, tick_step_q};
      held_d   = {{(CntW-StepW){1'b0}}, tick_step_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_step_q    <= RST_TICK_STEP;
      short_min_q    <= RST_SHORT_MIN;
      short_max_q    <= RST_SHORT_MAX;
      long_min_q     <= RST_LONG_MIN;
      long_max_q     <= RST_LONG_MAX;
      window_limit_q <= RST_WINDOW_LIMIT;
      window_q       <= '0;
      held_q         <= '0;
      pending_q      <= 1'b0;
      in_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          REG_TICK_STEP:    tick_step_q    <= cfg_i.data[StepW-1:0];
          REG_SHORT_MIN:    short_min_q    <= cfg_i.data;
          REG_SHORT_MAX:    short_max_q    <= cfg_i.data;
          REG_LONG_MIN:     long_min_q     <= cfg_i.data;
          REG_LONG_MAX:     long_max_q     <= cfg_i.data;
          REG_WINDOW_LIMIT: window_limit_q <= cfg_i.data;
          default: ;
        endcase
      end
      if (proc_en) begin
        window_q  <= window_d;
        held_q    <= held_d;
        pending_q <= pending_d;
      end
      if (tick_i.valid && tick_i.ready) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (tick_i.valid && tick_i.ready) begin
      level_q <= tick_i.button_level;
      edge_q  <= tick_i.button_edge;
    end
    if (proc_en) begin
      kind_q <= kind_d;
    end
  end

  `BPC_ASSERT(a_held_zero_when_closed, clk_i, rst_ni, (window_q == '0) |-> (held_q == '0))
  `BPC_ASSERT(a_word_reaches_output, clk_i, rst_ni, proc_en |=> out_valid_q)
  `BPC_ASSERT(a_double_clears_pending, clk_i, rst_ni,
              (proc_en && kind_d == KIND_DOUBLE) |=> !pending_q)
  `BPC_ASSERT_NEVER(a_no_accept_when_full, clk_i, rst_ni,
                    tick_i.ready && in_valid_q && out_valid_q && !press_o.ready)

endmodule
`default_nettype wire

>>> dv/bpc_press_checker.sv
// checker: predicts the press kind of every tick word and compares it with the block's results
module bpc_press_checker (
  input  logic clk_i,
  input  logic rst_ni,
  bpc_tick_if  tick_i,
  bpc_press_if press_i,
  bpc_cfg_if   cfg_i,
  output int   errors_o,
  output int   due_o,
  output int   shorts_o,
  output int   longs_o,
  output int   doubles_o,
  output int   unknowns_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import bpc_pkg::*;

  step_t step_q;
  thr_t  short_min_q;
  thr_t  short_max_q;
  thr_t  long_min_q;
  thr_t  long_max_q;
  thr_t  window_limit_q;
  cnt_t  window_q;
  cnt_t  held_q;
  logic  short_held_q;
  kind_t kinds_due[$];

  function automatic cnt_t sat_sum(cnt_t a, step_t b);
    logic [CntW:0] s;
    s = a + b;
    return s[CntW] ? '1 : s[CntW-1:0];
  endfunction

  function automatic kind_t held_class(cnt_t held);
    if (held < short_min_q) return KIND_UNKNOWN;
    if (held < short_max_q) return KIND_SHORT;
    if (held < long_min_q) return KIND_UNKNOWN;
    if (held < long_max_q) return KIND_LONG;
    return KIND_UNKNOWN;
  endfunction

  task automatic drop_window(inout edge_t e);
    e = '0;
    short_held_q = 1'b0;
    window_q = '0;
    held_q = '0;
  endtask

  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t d);
    case (idx)
      REG_TICK_STEP: step_q = d[StepW-1:0];
      REG_SHORT_MIN: short_min_q = d;
      REG_SHORT_MAX: short_max_q = d;
      REG_LONG_MIN: long_min_q = d;
      REG_LONG_MAX: long_max_q = d;
      REG_WINDOW_LIMIT: window_limit_q = d;
      default: ;
    endcase
  endtask

  task automatic advance_press(input logic level, input edge_t e_in, output kind_t kind);
    edge_t e;
    e = e_in;
    kind = KIND_NONE;
    if (window_q != '0) begin
      window_q = sat_sum(window_q, step_q);
      if (level) held_q = sat_sum(held_q, step_q);
      if (window_q > window_limit_q) begin
        kind = (held_q == window_q) ? KIND_LONG : KIND_NONE;
        drop_window(e);
      end else if (e == EDGE_FALL) begin
        kind = held_class(held_q);
        held_q = '0;
        if (kind == KIND_UNKNOWN) window_q = '0;
      end
      if (kind == KIND_SHORT) begin
        if (short_held_q) begin
          kind = KIND_DOUBLE;
          drop_window(e);
        end else begin
          kind = KIND_NONE;
          short_held_q = 1'b1;
        end
      end
      // held-back short expires once the double window is over
      if (short_held_q && window_q > short_max_q) begin
        kind = KIND_SHORT;
        drop_window(e);
      end
    end
    if (e == EDGE_RISE && window_q == '0) begin
      window_q = sat_sum(window_q, step_q);
      held_q = sat_sum(held_q, step_q);
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("%0t ns: press mismatch: %s", $time, what);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    kind_t got;
    kind_t want;
    kind_t kind;
    if (!rst_ni) begin
      step_q = RST_TICK_STEP;
      short_min_q = RST_SHORT_MIN;
      short_max_q = RST_SHORT_MAX;
      long_min_q = RST_LONG_MIN;
      long_max_q = RST_LONG_MAX;
      window_limit_q = RST_WINDOW_LIMIT;
      window_q = '0;
      held_q = '0;
      short_held_q = 1'b0;
      kinds_due.delete();
    end else begin
      if (press_i.valid && press_i.ready) begin
        got = press_i.press_kind;
        if (kinds_due.size() == 0) begin
          report_mismatch($sformatf("kind %0d with no tick word waiting", got));
        end else begin
          want = kinds_due.pop_front();
          if (got !== want) report_mismatch($sformatf("kind %0d, expected %0d", got, want));
          case (want)
            KIND_SHORT: shorts_o++;
            KIND_LONG: longs_o++;
            KIND_DOUBLE: doubles_o++;
            KIND_UNKNOWN: unknowns_o++;
            default: ;
          endcase
        end
      end
      if (cfg_i.valid && cfg_i.ready) write_reg(cfg_i.index, cfg_i.data);
      if (tick_i.valid && tick_i.ready) begin
        advance_press(tick_i.button_level, tick_i.button_edge, kind);
        kinds_due.push_back(kind);
      end
    end
    due_o = kinds_due.size();
  end

endmodule

>>> dv/button_press_classifier_tb.sv
// testbench top: tick and register stimulus, result back-pressure and verdict
module button_press_classifier_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bpc_pkg::*;

  localparam edge_t    EDGE_NONE = 2'd0;
  localparam edge_t    EDGE_RSVD = 2'd3;
  localparam cfg_idx_t REG_UNUSED_6 = 3'd6;
  localparam cfg_idx_t REG_UNUSED_7 = 3'd7;
  localparam int       HOLD_CAP = 90;

  logic clk;
  logic rst_n;
  int   errors;
  int   due;
  int   shorts;
  int   longs;
  int   doubles;
  int   unknowns;
  int   send_idle_pct;
  int   recv_idle_pct;
  logic hold_req;
  int   hold_left;
  int   ticks_sent;
  int   settings_made;
  int   cur_step;
  int   cur_short_min;
  int   cur_short_max;
  int   cur_long_min;
  int   cur_long_max;
  int   cur_window;

  bpc_tick_if  tick_bus ();
  bpc_press_if press_bus ();
  bpc_cfg_if   cfg_bus ();

  button_press_classifier DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .tick_i (tick_bus),
    .press_o(press_bus),
    .cfg_i  (cfg_bus)
  );

  bpc_press_checker press_check (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .tick_i    (tick_bus),
    .press_i   (press_bus),
    .cfg_i     (cfg_bus),
    .errors_o  (errors),
    .due_o     (due),
    .shorts_o  (shorts),
    .longs_o   (longs),
    .doubles_o (doubles),
    .unknowns_o(unknowns)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #4_000_000;
    $display("button_press_classifier verification failed");
    $finish;
  end

  // result side: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req && hold_left == 0) begin
      hold_left = 60;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      press_bus.ready <= 1'b0;
      hold_left--;
    end else begin
      press_bus.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  task automatic put_tick(input logic level, input edge_t e);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      tick_bus.valid <= 1'b0;
      @(negedge clk);
    end
    tick_bus.valid <= 1'b1;
    tick_bus.button_level <= level;
    tick_bus.button_edge <= e;
    @(posedge clk);
    while (!tick_bus.ready) @(posedge clk);
    @(negedge clk);
    ticks_sent++;
  endtask

  task automatic drain_results();
    tick_bus.valid <= 1'b0;
    while (due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input cfg_data_t d);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= d;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_thresholds(input cfg_data_t step_word, input thr_t smin, input thr_t smax,
                                input thr_t lmin, input thr_t lmax, input thr_t wlim);
    drain_results();
    cfg_write(REG_TICK_STEP, step_word);
    cfg_write(REG_SHORT_MIN, smin);
    cfg_write(REG_SHORT_MAX, smax);
    cfg_write(REG_LONG_MIN, lmin);
    cfg_write(REG_LONG_MAX, lmax);
    cfg_write(REG_WINDOW_LIMIT, wlim);
    cfg_write(REG_UNUSED_6, cfg_data_t'($urandom));
    cfg_write(REG_UNUSED_7, cfg_data_t'($urandom));
    cfg_bus.valid <= 1'b0;
    cur_step = step_word[StepW-1:0];
    cur_short_min = smin;
    cur_short_max = smax;
    cur_long_min = lmin;
    cur_long_max = lmax;
    cur_window = wlim;
    settings_made++;
  endtask

  task automatic directed_presses();
    set_thresholds(14'd100, 14'd100, 14'd400, 14'd500, 14'd700, 14'd900);
    // double short
    put_tick(1'b1, EDGE_RISE);
    put_tick(1'b0, EDGE_FALL);
    put_tick(1'b1, EDGE_RISE);
    put_tick(1'b0, EDGE_FALL);
    // single short after the double window runs out, reserved edge code on the way
    put_tick(1'b1, EDGE_RISE);
    put_tick(1'b0, EDGE_FALL);
    put_tick(1'b0, EDGE_NONE);
    put_tick(1'b0, EDGE_RSVD);
    put_tick(1'b0, EDGE_NONE);
    // release between short and long bands
    put_tick(1'b1, EDGE_RISE);
    repeat (3) put_tick(1'b1, EDGE_NONE);
    put_tick(1'b0, EDGE_FALL);
    // held through the window; the rise on the timeout tick is dropped
    put_tick(1'b1, EDGE_RISE);
    repeat (8) put_tick(1'b1, EDGE_NONE);
    put_tick(1'b1, EDGE_RISE);
    put_tick(1'b0, EDGE_NONE);
  endtask

  function automatic int pick_threshold();
    case ($urandom_range(4, 0))
      0: return cur_short_min;
      1: return cur_short_max;
      2: return cur_long_min;
      3: return cur_long_max;
      default: return cur_window;
    endcase
  endfunction

  task automatic random_presses(input int words);
    int stop_at;
    int step_eff;
    int hold;
    int gap;
    stop_at = ticks_sent + words;
    step_eff = (cur_step == 0) ? 1 : cur_step;
    while (ticks_sent < stop_at) begin
      if ($urandom_range(9, 0) < 2) begin
        put_tick(1'($urandom_range(1, 0)), edge_t'($urandom_range(3, 0)));
      end else begin
        hold = pick_threshold() / step_eff + int'($urandom_range(2, 0)) - 1;
        if (hold < 0) hold = 0;
        if (hold > HOLD_CAP) hold = HOLD_CAP;
        if ($urandom_range(3, 0) == 0) gap = pick_threshold() / step_eff + 1;
        else gap = int'($urandom_range(cur_short_max / step_eff + 2, 0));
        if (gap > HOLD_CAP) gap = HOLD_CAP;
        put_tick(1'b1, EDGE_RISE);
        repeat (hold) put_tick($urandom_range(9, 0) != 0, EDGE_NONE);
        put_tick($urandom_range(3, 0) == 0, EDGE_FALL);
        repeat (gap) put_tick(1'b0, ($urandom_range(7, 0) == 0) ? EDGE_RSVD : EDGE_NONE);
      end
    end
  endtask

  task automatic structured_setting();
    int s;
    int smin;
    int smax;
    int lmin;
    int lmax;
    s = $urandom_range(255, 1);
    smin = s * $urandom_range(3, 0);
    smax = smin + s * $urandom_range(5, 1);
    lmin = smax + s * $urandom_range(4, 0);
    lmax = lmin + s * $urandom_range(6, 1);
    set_thresholds({6'($urandom), 8'(s)}, thr_t'(smin), thr_t'(smax), thr_t'(lmin),
                   thr_t'(lmax), thr_t'(lmax + s * $urandom_range(8, 0)));
  endtask

  initial begin
    rst_n = 1'b0;
    tick_bus.valid = 1'b0;
    tick_bus.button_level = 1'b0;
    tick_bus.button_edge = EDGE_NONE;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = REG_TICK_STEP;
    cfg_bus.data = '0;
    press_bus.ready = 1'b0;
    hold_req = 1'b0;
    hold_left = 0;
    ticks_sent = 0;
    settings_made = 0;
    send_idle_pct = 37;
    recv_idle_pct = 77;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    directed_presses();
    for (int phase = 0; phase < 12; phase++) begin
      if (phase == 4) begin
        send_idle_pct = 77;
        recv_idle_pct = 37;
      end
      if (phase == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (phase)
        0: set_thresholds(cfg_data_t'(RST_TICK_STEP), RST_SHORT_MIN, RST_SHORT_MAX,
                          RST_LONG_MIN, RST_LONG_MAX, RST_WINDOW_LIMIT);
        1: set_thresholds('1, '1, '1, '1, '1, '1);
        2: set_thresholds(14'h3F01, '0, '0, '0, '0, '0);
        3: set_thresholds(14'h3F00, 14'd20, 14'd60, 14'd80, 14'd120, 14'd200);
        6, 10: set_thresholds(cfg_data_t'($urandom), thr_t'($urandom), thr_t'($urandom),
                              thr_t'($urandom), thr_t'($urandom), thr_t'($urandom));
        default: structured_setting();
      endcase
      if (phase == 8) hold_req = 1'b1;
      random_presses(130);
    end

    drain_results();
    repeat (8) @(negedge clk);
    $display("sent %0d tick words under %0d register settings, with stalls on both sides",
             ticks_sent, settings_made);
    $display("checked %0d short, %0d long, %0d double and %0d unknown presses",
             shorts, longs, doubles, unknowns);
    if (errors == 0 && due == 0) begin
      $display("button_press_classifier verification clean");
    end else begin
      $display("button_press_classifier verification failed");
    end
    $finish;
  end

endmodule

>>> button_press_classifier.f
+incdir+rtl
rtl/bpc_pkg.sv
rtl/bpc_if.sv
rtl/button_press_classifier.sv
dv/bpc_press_checker.sv
dv/button_press_classifier_tb.sv
